@@ hw/rtl/stb_pkg.sv @@
// shared constants, codes and request structs of the span tile binner
package stb_pkg;

  // screen and store geometry
  localparam int unsigned SCREEN_WIDTH  = 512;
  localparam int unsigned SCREEN_HEIGHT = 256;
  localparam int unsigned TILE_WIDTH    = 32;
  localparam int unsigned MAX_SPANS     = 4096;

  localparam int unsigned TILE_COLUMNS = (SCREEN_WIDTH + TILE_WIDTH - 1) / TILE_WIDTH;
  localparam int unsigned TILE_TOTAL   = TILE_COLUMNS * SCREEN_HEIGHT;
  localparam int unsigned HEADER_WORDS = TILE_TOTAL * 2;
  localparam int unsigned TABLE_DEPTH  = HEADER_WORDS + MAX_SPANS * TILE_COLUMNS;

  // field widths
  localparam int unsigned LEFT_W     = 9;
  localparam int unsigned RIGHT_W    = 10;
  localparam int unsigned ROW_W      = 8;
  localparam int unsigned WORD_W     = 17;
  localparam int unsigned COL_W      = $clog2(TILE_COLUMNS);
  localparam int unsigned TILE_AW    = ROW_W + COL_W;
  localparam int unsigned TILE_SHIFT = $clog2(TILE_WIDTH);
  localparam int unsigned SPAN_AW    = $clog2(MAX_SPANS);
  localparam int unsigned SPAN_CW    = SPAN_AW + 1;
  localparam int unsigned COUNT_W    = SPAN_CW;
  localparam int unsigned TABLE_AW   = $clog2(TABLE_DEPTH);

  // sized limits for compares
  localparam logic [RIGHT_W:0]   SCREEN_W_LIM  = (RIGHT_W + 1)'(SCREEN_WIDTH);
  localparam logic [ROW_W:0]     SCREEN_H_LIM  = (ROW_W + 1)'(SCREEN_HEIGHT);
  localparam logic [SPAN_CW-1:0] SPAN_LIM      = SPAN_CW'(MAX_SPANS);
  localparam logic [WORD_W-1:0]  HEADER_BASE   = WORD_W'(HEADER_WORDS);
  localparam logic [WORD_W-1:0]  TABLE_LIM     = WORD_W'(TABLE_DEPTH);
  localparam logic [TILE_AW-1:0] TILE_LAST     = TILE_AW'(TILE_TOTAL - 1);

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_FINAL = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_READ = 2'd2,
    ST_REJECT   = 2'd3
  } status_e;

  typedef struct packed {
    logic [LEFT_W-1:0]  left;
    logic [RIGHT_W-1:0] right;
    logic [ROW_W-1:0]   row;
  } span_rec_t;

  typedef struct packed {
    logic               we;
    logic [SPAN_AW-1:0] waddr;
    span_rec_t          wdata;
    logic [SPAN_AW-1:0] raddr;
  } span_req_t;

  typedef struct packed {
    logic               cnt_we;
    logic [TILE_AW-1:0] cnt_waddr;
    logic [COUNT_W-1:0] cnt_wdata;
    logic [TILE_AW-1:0] cnt_raddr;
    logic               cur_we;
    logic [TILE_AW-1:0] cur_waddr;
    logic [WORD_W-1:0]  cur_wdata;
    logic [TILE_AW-1:0] cur_raddr;
  } tile_req_t;

  typedef struct packed {
    logic                we;
    logic [TABLE_AW-1:0] waddr;
    logic [WORD_W-1:0]   wdata;
    logic [TABLE_AW-1:0] raddr;
  } table_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } alu_req_t;

endpackage

@@ hw/rtl/stb_in_if.sv @@
// input channel: command and span payload with valid/ready
interface stb_in_if;
  import stb_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [LEFT_W-1:0]  span_left;
  logic [RIGHT_W-1:0] span_right;
  logic [ROW_W-1:0]   span_row;
  logic [WORD_W-1:0]  word_index;

  modport source (
    output valid, mode, span_left, span_right, span_row, word_index,
    input  ready
  );

  modport sink (
    input  valid, mode, span_left, span_right, span_row, word_index,
    output ready
  );
endinterface

@@ hw/rtl/stb_out_if.sv @@
// output channel: result word, table size and status with valid/ready
interface stb_out_if;
  import stb_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word_value;
  logic [WORD_W-1:0] total_words;
  logic [1:0]        status;

  modport source (
    output valid, word_value, total_words, status,
    input  ready
  );

  modport sink (
    input  valid, word_value, total_words, status,
    output ready
  );
endinterface

@@ hw/rtl/stb_alu.sv @@
// shared adder used by every counting, prefix and cursor step
module stb_alu
  import stb_pkg::*;
(
  input  alu_req_t          req_i,
  output logic [WORD_W-1:0] sum_o
);

  // single word-wide add
  assign sum_o = req_i.a + req_i.b;

endmodule

@@ hw/rtl/stb_span_mem.sv @@
// span store: left, right and row of each added span
module stb_span_mem
  import stb_pkg::*;
(
  input  logic      clk_i,
  input  span_req_t req_i,
  output span_rec_t rdata_o
);

  span_rec_t mem_q [MAX_SPANS];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

@@ hw/rtl/stb_tile_mem.sv @@
// per-tile span counters and scatter cursors
module stb_tile_mem
  import stb_pkg::*;
(
  input  logic               clk_i,
  input  tile_req_t          req_i,
  output logic [COUNT_W-1:0] cnt_rdata_o,
  output logic [WORD_W-1:0]  cur_rdata_o
);

  logic [COUNT_W-1:0] cnt_mem_q [TILE_TOTAL];
  logic [WORD_W-1:0]  cur_mem_q [TILE_TOTAL];

  // counter memory
  always_ff @(posedge clk_i) begin
    if (req_i.cnt_we) begin
      cnt_mem_q[req_i.cnt_waddr] <= req_i.cnt_wdata;
    end
    cnt_rdata_o <= cnt_mem_q[req_i.cnt_raddr];
  end

  // cursor memory
  always_ff @(posedge clk_i) begin
    if (req_i.cur_we) begin
      cur_mem_q[req_i.cur_waddr] <= req_i.cur_wdata;
    end
    cur_rdata_o <= cur_mem_q[req_i.cur_raddr];
  end

endmodule

@@ hw/rtl/stb_table_mem.sv @@
// finished table: header pairs followed by the per-tile span lists
module stb_table_mem
  import stb_pkg::*;
(
  input  logic              clk_i,
  input  table_req_t        req_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem_q [TABLE_DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

@@ hw/rtl/span_tile_binner.sv @@
// top level: sequencer of the span tile binner
//
// Usage: commands enter on in_ch_i (valid/ready), one result leaves on
// out_ch_o per command. A transfer on in_ch_i happens only while the
// sequencer is idle; the block then stays busy until the command is done.
// Steps per command, set by the single adder and one port per memory:
//   add span  : counter update per touched tile (1 to 16), none if dropped
//   finalize  : 4096 header steps, then per span a fetch and tile writes
//   read word : registered table read
//   clear     : a pass that zeroes the 4096 tile counters
// After reset the same clearing pass runs with in_ch_i not
// ready; it produces no result.
// Results wait in an output register; while the receiver stalls the
// finished result holds there and the next command may already be taken
// and worked on, but its result is held back until the register frees.
// total_words reports the size of the last finalize, or zero after reset or a clear.
module span_tile_binner
  import stb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  stb_in_if.sink    in_ch_i,
  stb_out_if.source out_ch_o
);

  typedef enum logic [11:0] {
    S_CLR    = 12'b0000_0000_0001,
    S_IDLE   = 12'b0000_0000_0010,
    S_ADD_RD = 12'b0000_0000_0100,
    S_ADD_WR = 12'b0000_0000_1000,
    S_FH_RD  = 12'b0000_0001_0000,
    S_FH_OFS = 12'b0000_0010_0000,
    S_FH_CNT = 12'b0000_0100_0000,
    S_FS_RD  = 12'b0000_1000_0000,
    S_FS_LAT = 12'b0001_0000_0000,
    S_FS_CRD = 12'b0010_0000_0000,
    S_FS_WR  = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_e;

  state_e             state_q, state_d;
  logic               clr_cmd_q, clr_cmd_d;
  logic               rd_wait_q, rd_wait_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   x_q, x_d;
  logic [COL_W-1:0]   last_q, last_d;
  logic [TILE_AW-1:0] t_q, t_d;
  logic [WORD_W-1:0]  cursor_q, cursor_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [SPAN_AW-1:0] i_q, i_d;
  logic [SPAN_CW-1:0] span_total_q, span_total_d;
  logic [WORD_W-1:0]  words_q, words_d;
  logic               ready_q, ready_d;
  status_e            status_q, status_d;
  logic [WORD_W-1:0]  value_q, value_d;

  logic               out_valid_q, out_valid_d;
  logic [WORD_W-1:0]  out_value_q, out_value_d;
  logic [WORD_W-1:0]  out_words_q, out_words_d;
  status_e            out_status_q, out_status_d;

  span_req_t          span_req;
  span_rec_t          span_rdata;
  tile_req_t          tile_req;
  logic [COUNT_W-1:0] cnt_rdata;
  logic [WORD_W-1:0]  cur_rdata;
  table_req_t         table_req;
  logic [WORD_W-1:0]  table_rdata;
  alu_req_t           alu_req;
  logic [WORD_W-1:0]  alu_sum;

  logic               in_xfer;
  logic               span_ok;
  logic [RIGHT_W-1:0] in_right_m1;
  logic [RIGHT_W-1:0] st_right_m1;
  logic               out_free;

  stb_span_mem u_span_mem (
    .clk_i   (clk_i),
    .req_i   (span_req),
    .rdata_o (span_rdata)
  );

  stb_tile_mem u_tile_mem (
    .clk_i       (clk_i),
    .req_i       (tile_req),
    .cnt_rdata_o (cnt_rdata),
    .cur_rdata_o (cur_rdata)
  );

  stb_table_mem u_table_mem (
    .clk_i   (clk_i),
    .req_i   (table_req),
    .rdata_o (table_rdata)
  );

  stb_alu u_alu (
    .req_i (alu_req),
    .sum_o (alu_sum)
  );

  // handshake
  assign in_ch_i.ready = (state_q == S_IDLE);
  assign in_xfer       = in_ch_i.valid && in_ch_i.ready;
  assign out_free      = !out_valid_q || out_ch_o.ready;

  assign out_ch_o.valid       = out_valid_q;
  assign out_ch_o.word_value  = out_value_q;
  assign out_ch_o.total_words = out_words_q;
  assign out_ch_o.status      = out_status_q;

  // span checks
  assign span_ok = (RIGHT_W'(in_ch_i.span_left) < in_ch_i.span_right)
                   && ({1'b0, in_ch_i.span_right} <= SCREEN_W_LIM)
                   && ({1'b0, in_ch_i.span_row} < SCREEN_H_LIM);
  assign in_right_m1 = in_ch_i.span_right - RIGHT_W'(1);
  assign st_right_m1 = span_rdata.right - RIGHT_W'(1);

  // sequencer
  always_comb begin
    state_d      = state_q;
    clr_cmd_d    = clr_cmd_q;
    rd_wait_d    = 1'b0;
    row_d        = row_q;
    x_d          = x_q;
    last_d       = last_q;
    t_d          = t_q;
    cursor_d     = cursor_q;
    count_d      = count_q;
    i_d          = i_q;
    span_total_d = span_total_q;
    words_d      = words_q;
    ready_d      = ready_q;
    status_d     = status_q;
    value_d      = value_q;
    out_valid_d  = out_valid_q && !out_ch_o.ready;
    out_value_d  = out_value_q;
    out_words_d  = out_words_q;
    out_status_d = out_status_q;

    span_req       = '0;
    span_req.waddr = span_total_q[SPAN_AW-1:0];
    span_req.wdata = '{left: in_ch_i.span_left, right: in_ch_i.span_right,
                       row: in_ch_i.span_row};
    span_req.raddr = i_q;
    tile_req           = '0;
    tile_req.cnt_waddr = {row_q, x_q};
    tile_req.cnt_raddr = {row_q, x_q};
    tile_req.cur_waddr = {row_q, x_q};
    tile_req.cur_raddr = {row_q, x_q};
    table_req       = '0;
    table_req.raddr = in_ch_i.word_index;
    alu_req         = '0;

    case (state_q)
      // zero every tile counter
      S_CLR: begin
        tile_req.cnt_we    = 1'b1;
        tile_req.cnt_waddr = t_q;
        t_d                = t_q + TILE_AW'(1);
        if (t_q == TILE_LAST) begin
          state_d = clr_cmd_q ? S_DONE : S_IDLE;
        end
      end

      // decode a new command
      S_IDLE: begin
        if (in_xfer) begin
          value_d  = '0;
          status_d = ST_OK;
          case (mode_e'(in_ch_i.mode))
            MODE_ADD: begin
              if (!span_ok) begin
                status_d = ST_REJECT;
                state_d  = S_DONE;
              end else if (span_total_q == SPAN_LIM) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else begin
                span_req.we  = 1'b1;
                span_total_d = span_total_q + SPAN_CW'(1);
                ready_d      = 1'b0;
                row_d        = in_ch_i.span_row;
                x_d          = in_ch_i.span_left[TILE_SHIFT +: COL_W];
                last_d       = in_right_m1[TILE_SHIFT +: COL_W];
                state_d      = S_ADD_RD;
              end
            end
            MODE_FINAL: begin
              t_d      = '0;
              cursor_d = HEADER_BASE;
              state_d  = S_FH_RD;
            end
            MODE_READ: begin
              if (ready_q && (in_ch_i.word_index < words_q)) begin
                rd_wait_d = 1'b1;
              end else begin
                status_d = ST_BAD_READ;
              end
              state_d = S_DONE;
            end
            MODE_CLEAR: begin
              span_total_d = '0;
              words_d      = '0;
              ready_d      = 1'b0;
              t_d          = '0;
              clr_cmd_d    = 1'b1;
              state_d      = S_CLR;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      // count the span in each tile it covers
      S_ADD_RD: state_d = S_ADD_WR;

      S_ADD_WR: begin
        alu_req.a          = WORD_W'(cnt_rdata);
        alu_req.b          = WORD_W'(1);
        tile_req.cnt_we    = 1'b1;
        tile_req.cnt_wdata = alu_sum[COUNT_W-1:0];
        if (x_q == last_q) begin
          state_d = S_DONE;
        end else begin
          x_d     = x_q + COL_W'(1);
          state_d = S_ADD_RD;
        end
      end

      // header pass: prefix sum over tile counters
      S_FH_RD: begin
        tile_req.cnt_raddr = t_q;
        state_d            = S_FH_OFS;
      end

      S_FH_OFS: begin
        count_d            = cnt_rdata;
        table_req.we       = 1'b1;
        table_req.waddr    = TABLE_AW'({t_q, 1'b0});
        table_req.wdata    = cursor_q;
        tile_req.cur_we    = 1'b1;
        tile_req.cur_waddr = t_q;
        tile_req.cur_wdata = cursor_q;
        state_d            = S_FH_CNT;
      end

      S_FH_CNT: begin
        table_req.we    = 1'b1;
        table_req.waddr = TABLE_AW'({t_q, 1'b1});
        table_req.wdata = WORD_W'(count_q);
        alu_req.a       = cursor_q;
        alu_req.b       = WORD_W'(count_q);
        cursor_d        = alu_sum;
        t_d             = t_q + TILE_AW'(1);
        if (t_q == TILE_LAST) begin
          i_d = '0;
          if (span_total_q == '0) begin
            words_d = alu_sum;
            ready_d = 1'b1;
            state_d = S_DONE;
          end else begin
            state_d = S_FS_RD;
          end
        end else begin
          state_d = S_FH_RD;
        end
      end

      // scatter pass: fetch one stored span
      S_FS_RD: state_d = S_FS_LAT;

      S_FS_LAT: begin
        row_d   = span_rdata.row;
        x_d     = span_rdata.left[TILE_SHIFT +: COL_W];
        last_d  = st_right_m1[TILE_SHIFT +: COL_W];
        state_d = S_FS_CRD;
      end

      S_FS_CRD: state_d = S_FS_WR;

      // place the span index at the tile cursor and advance it
      S_FS_WR: begin
        table_req.we       = 1'b1;
        table_req.waddr    = cur_rdata;
        table_req.wdata    = WORD_W'(i_q);
        alu_req.a          = cur_rdata;
        alu_req.b          = WORD_W'(1);
        tile_req.cur_we    = 1'b1;
        tile_req.cur_wdata = alu_sum;
        if (x_q == last_q) begin
          if (({1'b0, i_q} + SPAN_CW'(1)) == span_total_q) begin
            words_d = cursor_q;
            ready_d = 1'b1;
            state_d = S_DONE;
          end else begin
            i_d     = i_q + SPAN_AW'(1);
            state_d = S_FS_RD;
          end
        end else begin
          x_d     = x_q + COL_W'(1);
          state_d = S_FS_CRD;
        end
      end

      // hand the result to the output register
      S_DONE: begin
        rd_wait_d = rd_wait_q;
        if (rd_wait_q) begin
          value_d   = table_rdata;
          rd_wait_d = 1'b0;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = value_q;
          out_words_d  = words_q;
          out_status_d = status_q;
          clr_cmd_d    = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control and payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      clr_cmd_q    <= 1'b0;
      rd_wait_q    <= 1'b0;
      t_q          <= '0;
      span_total_q <= '0;
      words_q      <= '0;
      ready_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_cmd_q    <= clr_cmd_d;
      rd_wait_q    <= rd_wait_d;
      t_q          <= t_d;
      span_total_q <= span_total_d;
      words_q      <= words_d;
      ready_q      <= ready_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q        <= row_d;
    x_q          <= x_d;
    last_q       <= last_d;
    cursor_q     <= cursor_d;
    count_q      <= count_d;
    i_q          <= i_d;
    status_q     <= status_d;
    value_q      <= value_d;
    out_value_q  <= out_value_d;
    out_words_q  <= out_words_d;
    out_status_q <= out_status_d;
  end

  // checks
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ch_i.ready)
    else $error("input taken again while a command is in progress");

  a_span_total_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_total_q <= SPAN_LIM)
    else $error("span count beyond store depth");

  a_words_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_words_q <= TABLE_LIM))
    else $error("table size beyond table depth");

  a_value_only_when_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_value_q != '0)) |-> (out_status_q == ST_OK))
    else $error("nonzero word with failing status");

endmodule

@@ sim/span_tile_binner_check.sv @@
`timescale 1ns / 100ps
// result checker of the span tile binner: predicts each result from input transfers and compares
module span_tile_binner_check
  import stb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  stb_in_if    in_ch,
  stb_out_if   out_ch,
  output int   pending_o,
  output int   fail_count_o
);

  typedef struct packed {
    logic [WORD_W-1:0] word_value;
    logic [WORD_W-1:0] total_words;
    status_e           status;
  } bin_result_t;

  // own copy of the binner state
  logic [LEFT_W-1:0]  span_left_mem  [MAX_SPANS];
  logic [RIGHT_W-1:0] span_right_mem [MAX_SPANS];
  logic [ROW_W-1:0]   span_row_mem   [MAX_SPANS];
  int unsigned        tile_hits      [TILE_TOTAL];
  int unsigned        tile_fill      [TILE_TOTAL];
  logic [WORD_W-1:0]  table_mem      [TABLE_DEPTH];
  int unsigned        spans_held;
  int unsigned        words_built;
  bit                 table_built;

  // results still owed by the block, oldest first
  bin_result_t        due_results [$];

  // empty the span store and the tile counters
  function automatic void clear_bins();
    foreach (tile_hits[t]) tile_hits[t] = 0;
    spans_held  = 0;
    words_built = 0;
    table_built = 1'b0;
  endfunction

  // prefix sum into headers, then scatter span indices in add order
  function automatic void build_table();
    int unsigned cursor;
    int unsigned tile;
    int unsigned first_col;
    int unsigned last_col;
    cursor = HEADER_WORDS;
    for (int unsigned t = 0; t < TILE_TOTAL; t++) begin
      table_mem[2*t]     = WORD_W'(cursor);
      table_mem[2*t + 1] = WORD_W'(tile_hits[t]);
      tile_fill[t]       = cursor;
      cursor             = cursor + tile_hits[t];
    end
    for (int unsigned i = 0; i < spans_held; i++) begin
      first_col = span_left_mem[i] / TILE_WIDTH;
      last_col  = (span_right_mem[i] - 1) / TILE_WIDTH;
      for (int unsigned x = first_col; x <= last_col && x < TILE_COLUMNS; x++) begin
        tile = span_row_mem[i] * TILE_COLUMNS + x;
        table_mem[tile_fill[tile]] = WORD_W'(i);
        tile_fill[tile] = tile_fill[tile] + 1;
      end
    end
    words_built = cursor;
    table_built = 1'b1;
  endfunction

  // carry out one command on the state and give the result it owes
  function automatic bin_result_t apply_command(mode_e mode, logic [LEFT_W-1:0] left,
                                                logic [RIGHT_W-1:0] right,
                                                logic [ROW_W-1:0] row,
                                                logic [WORD_W-1:0] index);
    bin_result_t res;
    int unsigned first_col;
    int unsigned last_col;
    res.word_value = '0;
    res.status     = ST_OK;
    case (mode)
      MODE_ADD: begin
        if (left >= right || right > SCREEN_WIDTH || row >= SCREEN_HEIGHT) begin
          res.status = ST_REJECT;
        end else if (spans_held >= MAX_SPANS) begin
          res.status = ST_FULL;
        end else begin
          span_left_mem[spans_held]  = left;
          span_right_mem[spans_held] = right;
          span_row_mem[spans_held]   = row;
          spans_held = spans_held + 1;
          first_col = left / TILE_WIDTH;
          last_col  = (right - 1) / TILE_WIDTH;
          for (int unsigned x = first_col; x <= last_col && x < TILE_COLUMNS; x++)
            tile_hits[row * TILE_COLUMNS + x] = tile_hits[row * TILE_COLUMNS + x] + 1;
          table_built = 1'b0;
        end
      end
      MODE_FINAL: build_table();
      MODE_READ: begin
        if (!table_built || index >= words_built) res.status = ST_BAD_READ;
        else res.word_value = table_mem[index];
      end
      default: clear_bins();
    endcase
    res.total_words = WORD_W'(words_built);
    return res;
  endfunction

  // output transfers are matched first, then the new input transfer is predicted
  always @(posedge clk_i or negedge rst_ni) begin : watch
    bin_result_t got;
    bin_result_t want;
    int bad;
    if (!rst_ni) begin
      clear_bins();
      due_results.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      bad = 0;
      if (out_ch.valid && out_ch.ready) begin
        got.word_value  = out_ch.word_value;
        got.total_words = out_ch.total_words;
        got.status      = status_e'(out_ch.status);
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result: word_value %0d total_words %0d status %0d",
                   $time, got.word_value, got.total_words, got.status);
          bad++;
        end else begin
          want = due_results.pop_front();
          if (got.word_value !== want.word_value) begin
            $display("%0t: word_value expected %0d actual %0d",
                     $time, want.word_value, got.word_value);
            bad++;
          end
          if (got.total_words !== want.total_words) begin
            $display("%0t: total_words expected %0d actual %0d",
                     $time, want.total_words, got.total_words);
            bad++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, got.status);
            bad++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        due_results.push_back(apply_command(mode_e'(in_ch.mode), in_ch.span_left,
                                            in_ch.span_right, in_ch.span_row,
                                            in_ch.word_index));
      pending_o <= due_results.size();
      if (bad != 0) fail_count_o <= fail_count_o + bad;
    end
  end

endmodule

@@ sim/span_tile_binner_test.sv @@
`timescale 1ns / 100ps
// testbench top of the span tile binner: clock, reset, command stimulus, receiver stalls, verdict
module span_tile_binner_test;
  import stb_pkg::*;

  localparam int QUIET_LIMIT  = 250000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 580;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } tile_pos_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  stb_in_if  in_ch ();
  stb_out_if out_ch ();

  int pending;
  int fail_count;
  int quiet_cycles = 0;
  int items_sent   = 0;
  int burst_left   = 0;
  bit hold_off_req = 1'b0;
  bit steady       = 1'b0;

  // rough tally of the table, only to aim reads at live words
  int unsigned stored_spans = 0;
  int unsigned list_words   = 0;
  tile_pos_t   recent_tiles [$];

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  span_tile_binner dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch)
  );

  span_tile_binner_check table_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: stretches of different stall patterns, plus one long hold-off on request
  initial begin : receiver
    int pattern;
    int stretch;
    out_ch.ready <= 1'b0;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        pattern = $urandom_range(0, 3);
        stretch = $urandom_range(20, 150);
        for (int k = 0; k < stretch && !hold_off_req; k++) begin
          case (pattern)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= 1'($urandom_range(0, 1));
            2: out_ch.ready <= ($urandom_range(0, 7) != 0);
            default: out_ch.ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // one command transfer; bursts with random gaps unless held steady
  task automatic send(input mode_e mode, input logic [LEFT_W-1:0] left,
                      input logic [RIGHT_W-1:0] right, input logic [ROW_W-1:0] row,
                      input logic [WORD_W-1:0] index);
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.span_left  <= left;
    in_ch.span_right <= right;
    in_ch.span_row   <= row;
    in_ch.word_index <= index;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
    if (!steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic add_span(input logic [LEFT_W-1:0] left, input logic [RIGHT_W-1:0] right,
                          input logic [ROW_W-1:0] row);
    int unsigned first_col;
    int unsigned last_col;
    if (left < right && right <= SCREEN_WIDTH && stored_spans < MAX_SPANS) begin
      first_col = left / TILE_WIDTH;
      last_col  = (right - 1) / TILE_WIDTH;
      stored_spans++;
      list_words += last_col - first_col + 1;
      recent_tiles.push_back('{row, COL_W'($urandom_range(first_col, last_col))});
      if (recent_tiles.size() > 64) void'(recent_tiles.pop_front());
    end
    send(MODE_ADD, left, right, row, WORD_W'($urandom));
  endtask

  // valid span, mostly short, sometimes up to the full width
  task automatic add_random_span(input int unsigned max_len);
    int unsigned len;
    int unsigned left;
    int unsigned right;
    left  = $urandom_range(0, SCREEN_WIDTH - 1);
    len   = $urandom_range(1, max_len);
    right = left + len;
    if (right > SCREEN_WIDTH) right = SCREEN_WIDTH;
    add_span(LEFT_W'(left), RIGHT_W'(right), ROW_W'($urandom));
  endtask

  task automatic add_some_span();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) add_random_span(40);
    else if (sel < 9) add_random_span(200);
    else add_random_span(SCREEN_WIDTH);
  endtask

  // broken spans: empty or reversed, past the screen edge, or any bits at all
  task automatic add_bad_span();
    int unsigned sel;
    int unsigned right;
    sel = $urandom_range(0, 3);
    if (sel < 2) begin
      right = $urandom_range(0, SCREEN_WIDTH - 1);
      add_span(LEFT_W'($urandom_range(right, SCREEN_WIDTH - 1)), RIGHT_W'(right),
               ROW_W'($urandom));
    end else if (sel == 2) begin
      add_span(LEFT_W'($urandom), RIGHT_W'($urandom_range(SCREEN_WIDTH + 1, 1023)),
               ROW_W'($urandom));
    end else begin
      add_span(LEFT_W'($urandom), RIGHT_W'($urandom), ROW_W'($urandom));
    end
  endtask

  task automatic finalize();
    send(MODE_FINAL, LEFT_W'($urandom), RIGHT_W'($urandom), ROW_W'($urandom),
         WORD_W'($urandom));
  endtask

  task automatic clear_bins();
    stored_spans = 0;
    list_words   = 0;
    recent_tiles.delete();
    send(MODE_CLEAR, LEFT_W'($urandom), RIGHT_W'($urandom), ROW_W'($urandom),
         WORD_W'($urandom));
  endtask

  task automatic read_word(input logic [WORD_W-1:0] index);
    send(MODE_READ, LEFT_W'($urandom), RIGHT_W'($urandom), ROW_W'($urandom), index);
  endtask

  // reads aimed at headers of used tiles, list words, and just past the end
  task automatic read_aimed();
    int unsigned sel;
    int unsigned index;
    tile_pos_t   pos;
    sel = $urandom_range(0, 19);
    if (sel < 8 && recent_tiles.size() != 0) begin
      pos   = recent_tiles[$urandom_range(0, recent_tiles.size() - 1)];
      index = 2 * (pos.row * TILE_COLUMNS + pos.col) + $urandom_range(0, 1);
    end else if (sel < 14 && list_words != 0) begin
      index = HEADER_WORDS + $urandom_range(0, list_words - 1);
    end else if (sel < 17) begin
      index = $urandom_range(0, HEADER_WORDS - 1);
    end else if (sel < 19) begin
      index = HEADER_WORDS + list_words + $urandom_range(0, 3);
    end else begin
      index = $urandom;
    end
    read_word(WORD_W'(index));
  endtask

  // any command with any fields
  task automatic noise_item();
    case (mode_e'($urandom_range(0, 3)))
      MODE_ADD:   add_span(LEFT_W'($urandom), RIGHT_W'($urandom), ROW_W'($urandom));
      MODE_FINAL: finalize();
      MODE_READ:  read_word(WORD_W'($urandom));
      default:    clear_bins();
    endcase
  endtask

  // sender pauses until every owed result has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin : stimulus
    int n;
    int random_start;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= MODE_ADD;
    in_ch.span_left  <= '0;
    in_ch.span_right <= '0;
    in_ch.span_row   <= '0;
    in_ch.word_index <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reads before any table, empty table, field extremes, rejects
    read_word('0);
    finalize();
    read_word('0);
    read_word(WORD_W'(HEADER_WORDS - 1));
    read_word(WORD_W'(HEADER_WORDS));
    read_word('1);
    add_span(9'd0, RIGHT_W'(SCREEN_WIDTH), 8'd255);
    add_span(9'd511, RIGHT_W'(SCREEN_WIDTH), 8'd0);
    add_span(9'd31, 10'd33, 8'd128);
    add_span(9'd100, 10'd100, 8'd7);
    add_span(9'd200, 10'd50, 8'd7);
    add_span(9'd0, RIGHT_W'(SCREEN_WIDTH + 1), 8'd7);
    add_span(9'd511, 10'd1023, 8'd7);
    add_span(9'd0, 10'd0, 8'd0);
    // table went stale with the adds
    read_word('0);
    finalize();
    read_word(WORD_W'(HEADER_WORDS));
    read_word(WORD_W'(HEADER_WORDS + list_words - 1));
    read_word(WORD_W'(2 * (255 * TILE_COLUMNS) + 1));
    read_word(WORD_W'(HEADER_WORDS + list_words));

    // long receiver hold-off while reads keep coming, block fills up
    hold_off_req = 1'b1;
    steady = 1'b1;
    repeat (30) read_aimed();
    steady = 1'b0;
    wait_drained();
    clear_bins();
    read_word('0);

    // one valid and one broken span, then a fresh table and reads
    add_span(9'd10, 10'd20, 8'd3);
    add_bad_span();
    finalize();
    repeat (12) read_aimed();
    clear_bins();

    // random: adds, finalize, reads, with stale tables and noise mixed in
    random_start = items_sent;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0 || stored_spans > 3000) clear_bins();
      n = $urandom_range(2, 30);
      repeat (n) begin
        if ($urandom_range(0, 6) == 0) add_bad_span();
        else add_some_span();
      end
      if ($urandom_range(0, 9) != 0) finalize();
      n = $urandom_range(4, 30);
      repeat (n) begin
        if ($urandom_range(0, 19) == 0) noise_item();
        else read_aimed();
      end
      if ($urandom_range(0, 3) == 0) begin
        add_some_span();
        repeat ($urandom_range(1, 4)) read_aimed();
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
